### rtl/core/euler_angles_to_quaternion_assert.svh
// assertion macros for the euler angles to quaternion block
// used by the top level; expects aclk and aresetn in scope
`ifndef EULER_ANGLES_TO_QUATERNION_ASSERT_SVH
`define EULER_ANGLES_TO_QUATERNION_ASSERT_SVH
`ifndef SYNTH
`define EAQ_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("eaq assertion failed");
`define EAQ_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("eaq reset assertion failed");
`else
`define EAQ_ASSERT(label, prop)
`define EAQ_ASSERT_RST(label, prop)
`endif
`endif

### rtl/core/eaq_pkg.sv
// shared types and constants for the euler angles to quaternion block
// no dependencies
`timescale 1ns / 1ps
package eaq_pkg;

    localparam int ZW = 33;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [ZW-1:0] KGAIN = 33'sd652032874;
    localparam logic signed [ZW-1:0] TURN_HALF = 33'sd2147483648;
    localparam logic signed [ZW-1:0] TURN_QUARTER = 33'sd1073741824;
    localparam logic [31:0] DEG_SCALE = 32'd46603;
    localparam logic [40:0] RECIP45 = 41'd1491308;
    localparam logic [19:0] DIV45 = 20'd45;
    localparam logic [19:0] SCALE_REM = 20'd17;
    localparam logic [19:0] ROUND_BIAS = 20'd22;

    localparam logic [31:0] ATAN_TBL [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
        32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304,
        32'd652, 32'd326, 32'd163, 32'd81
    };

    typedef struct packed {
        logic signed [ZW-1:0] x;
        logic signed [ZW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } cordic_t;

endpackage

### rtl/core/euler_angles_to_quaternion.sv
// top level: yaw/pitch/roll in 1/128 degree to a Q2.14 rotation quaternion
// depends on eaq_pkg, eaq_angle_prep, eaq_cordic_cell, eaq_quat_mul
//
// input request on s_axis: s_tdata holds yaw_angle [15:0], pitch_angle [31:16],
// roll_angle [47:32], all signed 1/128 degree
// result request on m_axis: m_tdata holds quat_x, quat_y, quat_z, quat_w,
// 16 bits each from the lowest bit up, signed Q2.14
// one request is taken per cycle unless the pipeline is stalled; a result passes
// through four angle scaling stages, one cordic cell per stage, one rounding
// stage and four quaternion product stages
// the whole pipeline advances in lockstep; when m_tready is low with a
// result waiting, every stage holds and s_tready drops in the same cycle
// reset empties the pipeline and drops m_tvalid; no clearing pass is needed
`timescale 1ns / 1ps
`include "euler_angles_to_quaternion_assert.svh"
module euler_angles_to_quaternion
    import eaq_pkg::*;
#(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS = 14
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // yaw_angle, pitch_angle, roll_angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata   // quat_x, quat_y, quat_z, quat_w
);

    localparam int LAT = CORDIC_STAGES + 9;

    logic [LAT-1:0]     vld_reg;
    logic               en;
    logic signed [15:0] ang [3];
    cordic_t            chain [3][CORDIC_STAGES+1];
    cordic_t            rot [3];
    logic signed [15:0] qx, qy, qz, qw;

    assign en = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign ang[0] = s_tdata[15:0];
    assign ang[1] = s_tdata[31:16];
    assign ang[2] = s_tdata[47:32];

    genvar a, i;
    generate
        for (a = 0; a < 3; a++) begin : g_axis
            eaq_angle_prep u_prep (
                .aclk  (aclk),
                .en    (en),
                .angle (ang[a]),
                .out   (chain[a][0])
            );
            for (i = 0; i < CORDIC_STAGES; i++) begin : g_cell
                eaq_cordic_cell #(.IDX(i)) u_cell (
                    .aclk (aclk),
                    .en   (en),
                    .din  (chain[a][i]),
                    .dout (chain[a][i+1])
                );
            end
            assign rot[a] = chain[a][CORDIC_STAGES];
        end
    endgenerate

    eaq_quat_mul #(.FRAC_BITS(FRAC_BITS)) u_qmul (
        .aclk   (aclk),
        .en     (en),
        .rot    (rot),
        .quat_x (qx),
        .quat_y (qy),
        .quat_z (qz),
        .quat_w (qw)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata = {qw, qz, qy, qx};

    `EAQ_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid)
    `EAQ_ASSERT(a_stall_holds, !en |=> $stable(vld_reg))
    `EAQ_ASSERT(a_held_result, m_tvalid && !m_tready |=> m_tvalid)
    `EAQ_ASSERT(a_range, m_tvalid |-> ($signed(qx) >= -16384 && $signed(qx) <= 16384 && $signed(qy) >= -16384 && $signed(qy) <= 16384 && $signed(qz) >= -16384 && $signed(qz) <= 16384 && $signed(qw) >= -16384 && $signed(qw) <= 16384))

endmodule

### rtl/core/eaq_angle_prep.sv
// negates, halves and scales one angle to a folded binary angle
// depends on eaq_pkg
`timescale 1ns / 1ps
module eaq_angle_prep
    import eaq_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] angle,
    output cordic_t            out
);

    logic [15:0] mag1_reg;
    logic        neg1_reg;
    logic [31:0] p1_2_reg;
    logic [40:0] p2_2_reg;
    logic [19:0] v2_reg;
    logic        neg2_reg;
    logic [31:0] p1_3_reg;
    logic [14:0] q3_reg;
    logic        neg3_reg;
    cordic_t     out_reg;

    logic signed [16:0] n_next;
    logic [16:0]        mag_next;
    logic [19:0]        v_next;
    logic [14:0]        qd;
    logic [19:0]        rem;
    logic [14:0]        q_next;
    logic signed [ZW-1:0] zm;
    logic signed [ZW-1:0] zs;
    cordic_t            out_next;

    always_comb begin
        n_next = -{angle[15], angle};
        mag_next = n_next[16] ? 17'(-n_next) : 17'(n_next);
        v_next = 20'(mag1_reg) * SCALE_REM + ROUND_BIAS;
        qd = p2_2_reg[40:26];
        rem = v2_reg - 20'(qd) * DIV45;
        q_next = (rem >= DIV45) ? qd + 15'd1 : qd;
        zm = $signed({1'b0, p1_3_reg}) + $signed(ZW'(q3_reg));
        zs = neg3_reg ? -zm : zm;
        out_next.x = KGAIN;
        out_next.y = '0;
        out_next.flip = 1'b0;
        out_next.z = zs;
        if (zs > TURN_QUARTER) begin
            out_next.z = zs - TURN_HALF;
            out_next.flip = 1'b1;
        end else if (zs < -TURN_QUARTER) begin
            out_next.z = zs + TURN_HALF;
            out_next.flip = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg <= mag_next[15:0];
            neg1_reg <= n_next[16];
            p1_2_reg <= 32'(mag1_reg) * DEG_SCALE;
            p2_2_reg <= 41'(v_next) * RECIP45;
            v2_reg <= v_next;
            neg2_reg <= neg1_reg;
            p1_3_reg <= p1_2_reg;
            q3_reg <= q_next;
            neg3_reg <= neg2_reg;
            out_reg <= out_next;
        end
    end

    assign out = out_reg;

endmodule

### rtl/core/eaq_cordic_cell.sv
// one rotation stage of the cordic chain
// depends on eaq_pkg
`timescale 1ns / 1ps
module eaq_cordic_cell
    import eaq_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic    aclk,
    input  logic    en,
    input  cordic_t din,
    output cordic_t dout
);

    localparam logic signed [ZW-1:0] STEP = $signed({1'b0, ATAN_TBL[IDX]});

    cordic_t cell_reg;
    cordic_t cell_next;

    always_comb begin
        cell_next.flip = din.flip;
        if (din.z >= 0) begin
            cell_next.x = din.x - (din.y >>> IDX);
            cell_next.y = din.y + (din.x >>> IDX);
            cell_next.z = din.z - STEP;
        end else begin
            cell_next.x = din.x + (din.y >>> IDX);
            cell_next.y = din.y - (din.x >>> IDX);
            cell_next.z = din.z + STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

### rtl/core/eaq_quat_mul.sv
// rounds sine and cosine and forms qyaw * (qpitch * qroll)
// depends on eaq_pkg; index 0 yaw, 1 pitch, 2 roll
`timescale 1ns / 1ps
module eaq_quat_mul
    import eaq_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic               aclk,
    input  logic               en,
    input  cordic_t            rot [3],
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z,
    output logic signed [15:0] quat_w
);

    localparam int CW = FRAC_BITS + 3;
    localparam int PW = 2 * CW;
    localparam int SH0 = 30 - FRAC_BITS;
    localparam int SH2 = 2 * FRAC_BITS - 14;
    localparam logic signed [PW:0] HALF1 = (PW+1)'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [PW:0] HALF2 = (PW+1)'(1) <<< (SH2 - 1);
    localparam logic signed [PW:0] SAT_HI = (PW+1)'(16384);
    localparam logic signed [PW:0] SAT_LO = -(PW+1)'(16384);

    logic signed [CW-1:0] sn_reg [3];
    logic signed [CW-1:0] cs_reg [3];
    logic signed [PW-1:0] a_reg [4];
    logic signed [CW-1:0] sy1_reg, cy1_reg, sy2_reg, cy2_reg;
    logic signed [CW-1:0] m_reg [4];
    logic signed [PW-1:0] b_reg [8];
    logic signed [15:0]   q_reg [4];

    logic signed [CW-1:0] sn_next [3];
    logic signed [CW-1:0] cs_next [3];
    logic signed [PW:0]   mw [4];
    logic signed [PW:0]   mr [4];
    logic signed [PW:0]   sw [4];
    logic signed [PW:0]   sr [4];
    logic signed [15:0]   q_next [4];

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_round
            logic signed [ZW-1:0] xv, yv;
            always_comb begin
                xv = rot[g].flip ? -rot[g].x : rot[g].x;
                yv = rot[g].flip ? -rot[g].y : rot[g].y;
            end
            if (SH0 == 0) begin : g_noshift
                assign cs_next[g] = xv[CW-1:0];
                assign sn_next[g] = yv[CW-1:0];
            end else begin : g_shift
                localparam logic signed [ZW-1:0] HALF0 = ZW'(1) <<< (SH0 - 1);
                logic signed [ZW-1:0] xs, ys;
                always_comb begin
                    xs = (xv + HALF0) >>> SH0;
                    ys = (yv + HALF0) >>> SH0;
                end
                assign cs_next[g] = xs[CW-1:0];
                assign sn_next[g] = ys[CW-1:0];
            end
        end
    endgenerate

    always_comb begin
        mw[0] = (PW+1)'(a_reg[0]);
        mw[1] = -(PW+1)'(a_reg[1]);
        mw[2] = (PW+1)'(a_reg[2]);
        mw[3] = (PW+1)'(a_reg[3]);
        sw[0] = (PW+1)'(b_reg[0]) + (PW+1)'(b_reg[1]);
        sw[1] = (PW+1)'(b_reg[2]) + (PW+1)'(b_reg[3]);
        sw[2] = (PW+1)'(b_reg[4]) - (PW+1)'(b_reg[5]);
        sw[3] = (PW+1)'(b_reg[6]) - (PW+1)'(b_reg[7]);
        for (int k = 0; k < 4; k++) begin
            mr[k] = (mw[k] + HALF1) >>> FRAC_BITS;
            sr[k] = (sw[k] + HALF2) >>> SH2;
            if (sr[k] > SAT_HI) begin
                q_next[k] = 16'sd16384;
            end else if (sr[k] < SAT_LO) begin
                q_next[k] = -16'sd16384;
            end else begin
                q_next[k] = sr[k][15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                sn_reg[k] <= sn_next[k];
                cs_reg[k] <= cs_next[k];
            end
            // pitch * roll
            a_reg[0] <= PW'(sn_reg[1]) * PW'(cs_reg[2]);
            a_reg[1] <= PW'(sn_reg[1]) * PW'(sn_reg[2]);
            a_reg[2] <= PW'(cs_reg[1]) * PW'(sn_reg[2]);
            a_reg[3] <= PW'(cs_reg[1]) * PW'(cs_reg[2]);
            sy1_reg <= sn_reg[0];
            cy1_reg <= cs_reg[0];
            for (int k = 0; k < 4; k++) begin
                m_reg[k] <= mr[k][CW-1:0];
            end
            sy2_reg <= sy1_reg;
            cy2_reg <= cy1_reg;
            // yaw * mid
            b_reg[0] <= PW'(cy2_reg) * PW'(m_reg[0]);
            b_reg[1] <= PW'(sy2_reg) * PW'(m_reg[2]);
            b_reg[2] <= PW'(cy2_reg) * PW'(m_reg[1]);
            b_reg[3] <= PW'(sy2_reg) * PW'(m_reg[3]);
            b_reg[4] <= PW'(cy2_reg) * PW'(m_reg[2]);
            b_reg[5] <= PW'(sy2_reg) * PW'(m_reg[0]);
            b_reg[6] <= PW'(cy2_reg) * PW'(m_reg[3]);
            b_reg[7] <= PW'(sy2_reg) * PW'(m_reg[1]);
            for (int k = 0; k < 4; k++) begin
                q_reg[k] <= q_next[k];
            end
        end
    end

    assign quat_x = q_reg[0];
    assign quat_y = q_reg[1];
    assign quat_z = q_reg[2];
    assign quat_w = q_reg[3];

endmodule

### test/tb_top.sv
// testbench for euler_angles_to_quaternion: random and directed pose samples,
// results checked against a behavioral model of the cordic and quaternion products
// depends on eaq_pkg and the euler_angles_to_quaternion rtl
`timescale 1ns / 1ps
module tb_top;
    import eaq_pkg::*;

    localparam int STAGES = 16;
    localparam int FB = 14;
    localparam int LATENCY = STAGES + 9;
    localparam int ONE_Q = 16384;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } pose_t;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } quat_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;  // yaw_angle, pitch_angle, roll_angle
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;  // quat_x, quat_y, quat_z, quat_w

    pose_t pending_poses[$];
    bit    pause_marks[$];
    quat_t expected_quats[$];
    int    send_idle_pct;
    int    recv_stall_pct;
    int    hold_cycles;
    int    errors;
    longint cycle_count;

    euler_angles_to_quaternion #(.CORDIC_STAGES(STAGES), .FRAC_BITS(FB)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_sh(longint v, int s);
        if (s == 0) return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // sine and cosine of the negated half angle
    task automatic half_angle_sincos(input logic signed [15:0] ang, output longint sn,
                                     output longint cs);
        longint n, mag, z, x, y, dx, dy;
        bit flip;
        n = -longint'(ang);
        mag = (n < 0) ? -n : n;
        z = (mag * (longint'(1) << 21) + 22) / 45;
        if (n < 0) z = -z;
        flip = 0;
        if (z > longint'(TURN_QUARTER)) begin
            z -= longint'(TURN_HALF);
            flip = 1;
        end else if (z < -longint'(TURN_QUARTER)) begin
            z += longint'(TURN_HALF);
            flip = 1;
        end
        x = longint'(KGAIN);
        y = 0;
        for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TBL[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TBL[i]);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        cs = round_sh(x, 30 - FB);
        sn = round_sh(y, 30 - FB);
    endtask

    task automatic hamilton(input longint l[4], input longint r[4], output longint o[4],
                            input int s);
        o[0] = round_sh(l[3]*r[0] + l[0]*r[3] + l[1]*r[2] - l[2]*r[1], s);
        o[1] = round_sh(l[3]*r[1] + l[1]*r[3] + l[2]*r[0] - l[0]*r[2], s);
        o[2] = round_sh(l[3]*r[2] + l[2]*r[3] + l[0]*r[1] - l[1]*r[0], s);
        o[3] = round_sh(l[3]*r[3] - l[0]*r[0] - l[1]*r[1] - l[2]*r[2], s);
    endtask

    task automatic predict_quat(input pose_t p, output quat_t q);
        longint qy[4], qp[4], qr[4], mid[4], res[4];
        qy = '{0, 0, 0, 0};
        qp = '{0, 0, 0, 0};
        qr = '{0, 0, 0, 0};
        half_angle_sincos(p.yaw, qy[1], qy[3]);
        half_angle_sincos(p.pitch, qp[0], qp[3]);
        half_angle_sincos(p.roll, qr[2], qr[3]);
        hamilton(qp, qr, mid, FB);
        hamilton(qy, mid, res, 2 * FB - 14);
        for (int k = 0; k < 4; k++) begin
            if (res[k] > ONE_Q) res[k] = ONE_Q;
            if (res[k] < -ONE_Q) res[k] = -ONE_Q;
        end
        q.x = res[0][15:0];
        q.y = res[1][15:0];
        q.z = res[2][15:0];
        q.w = res[3][15:0];
    endtask

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // driver
    always @(posedge aclk) begin
        quat_t q;
        if (!aresetn) begin
            s_tvalid <= 0;
            s_tdata <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_quat(pose_t'(s_tdata), q);
                expected_quats.push_back(q);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_poses.size() > 0 && pause_marks[0]) begin
                    // pause marker: wait for the pipeline to drain
                    s_tvalid <= 0;
                    if (expected_quats.size() == 0 && !(s_tvalid && s_tready)) begin
                        void'(pending_poses.pop_front());
                        void'(pause_marks.pop_front());
                    end
                end else if (pending_poses.size() > 0 &&
                             $urandom_range(99, 0) >= send_idle_pct) begin
                    s_tdata <= pending_poses.pop_front();
                    void'(pause_marks.pop_front());
                    s_tvalid <= 1;
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // receiver stall
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        quat_t got, exp_q;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_quats.size() == 0) begin
                $error("result request with none expected: %h", m_tdata);
                errors++;
            end else begin
                exp_q = expected_quats.pop_front();
                if (got.x !== exp_q.x) begin
                    $error("quat_x expected %0d actual %0d", exp_q.x, got.x); errors++;
                end
                if (got.y !== exp_q.y) begin
                    $error("quat_y expected %0d actual %0d", exp_q.y, got.y); errors++;
                end
                if (got.z !== exp_q.z) begin
                    $error("quat_z expected %0d actual %0d", exp_q.z, got.z); errors++;
                end
                if (got.w !== exp_q.w) begin
                    $error("quat_w expected %0d actual %0d", exp_q.w, got.w); errors++;
                end
            end
        end
    end

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(9, 0))
            0: return 16'($urandom);
            1: return 16'($urandom_range(23040, 0)) * 16'sd1 * ($urandom_range(1, 0) ? 1 : -1);
            2: return $urandom_range(1, 0) ? 16'sd11520 : -16'sd11520;
            default: return 16'($urandom_range(46080, 0)) - 16'sd23040;
        endcase
    endfunction

    task automatic add_pose(input int yv, input int pv, input int rv);
        pose_t p;
        p.yaw = yv; p.pitch = pv; p.roll = rv;
        pending_poses.push_back(p);
        pause_marks.push_back(1'b0);
    endtask

    task automatic add_pause();
        pending_poses.push_back('0);
        pause_marks.push_back(1'b1);
    endtask

    task automatic add_random(input int count);
        for (int i = 0; i < count; i++)
            add_pose(rand_angle(), rand_angle(), rand_angle());
    endtask

    task automatic wait_drained();
        while (pending_poses.size() > 0 || s_tvalid || expected_quats.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        int edge_vals[8];
        edge_vals = '{0, 23040, -23040, 32767, -32768, 11520, -11520, 1};
        errors = 0;
        cycle_count = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1;

        // directed: extremes, quarter and half turns, wrapped values
        for (int i = 0; i < 8; i++)
            add_pose(edge_vals[i], edge_vals[(i + 3) % 8], edge_vals[(i + 5) % 8]);
        add_pose(0, 0, 0);
        add_pose(23040, 0, 0);
        add_pose(0, 23040, 0);
        add_pose(0, 0, 23040);
        add_pose(11521, -11521, 11519);
        add_pose(-1, -1, -1);
        add_pose(16'h5555, 16'haaaa, 16'h5555);
        add_pose(16'haaaa, 16'h5555, 16'haaaa);
        wait_drained();

        add_random(350);
        wait_drained();
        send_idle_pct = 62;
        add_random(300);
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 62;
        add_random(300);
        // long receiver hold-off while the sender keeps offering
        hold_cycles = 200;
        add_random(100);
        wait_drained();
        send_idle_pct = 6;
        recv_stall_pct = 6;
        add_random(150);
        add_pause();  // sender pause until all results are back
        add_random(200);
        wait_drained();
        repeat (LATENCY + 5) @(posedge aclk);
        if (errors == 0)
            $display("euler_angles_to_quaternion test passed");
        else
            $display("euler_angles_to_quaternion test failed");
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("euler_angles_to_quaternion test failed");
        $finish;
    end
endmodule

### euler_angles_to_quaternion.f
+incdir+rtl/core
rtl/core/eaq_pkg.sv
rtl/core/eaq_angle_prep.sv
rtl/core/eaq_cordic_cell.sv
rtl/core/eaq_quat_mul.sv
rtl/core/euler_angles_to_quaternion.sv
test/tb_top.sv
